// File: rtl/lru_tag_cache_lookup_assert.svh
// Assertion macros for the LRU tag cache lookup checker.
`ifndef LRU_TAG_CACHE_LOOKUP_ASSERT_SVH
`define LRU_TAG_CACHE_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LTCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define LTCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ltcl_pkg.sv
// Package: types and constants for the LRU tag cache lookup.
`timescale 1ns / 1ps

package ltcl_pkg;

    localparam int CP_W          = 21;
    localparam int FONT_W        = 16;
    localparam int STAMP_W       = 32;
    localparam int SLOT_W        = 6;
    localparam int SLOTS_DEFAULT = 64;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [FONT_W-1:0] font_number;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_index;
        logic              evicted;
    } rsp_t;

    // One word of the tag store.
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [FONT_W-1:0]  font_number;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

// File: rtl/ltcl_tag_ram.sv
// Tag store memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ltcl_tag_ram #(
    parameter int SLOTS = ltcl_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  ltcl_pkg::entry_t         wdata,
    input  logic                     re,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output ltcl_pkg::entry_t         rdata
);

    ltcl_pkg::entry_t entry_mem [SLOTS];
    ltcl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// File: rtl/ltcl_scan.sv
// Scan accumulator: first matching live entry and oldest stamp over one pass.
`timescale 1ns / 1ps

module ltcl_scan #(
    parameter int SLOTS = ltcl_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       vld,
    input  logic [$clog2(SLOTS)-1:0]   idx,
    input  ltcl_pkg::entry_t           entry,
    input  ltcl_pkg::req_t             req,
    input  logic [$clog2(SLOTS+1)-1:0] fill,
    output logic                       found,
    output logic [$clog2(SLOTS)-1:0]   hit_idx,
    output logic [$clog2(SLOTS)-1:0]   old_idx
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS+1);

    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]             old_idx_reg, old_idx_next;
    logic [ltcl_pkg::STAMP_W-1:0] oldest_reg, oldest_next;
    logic                         live;
    logic                         match;

    // Entries fill strictly in index order, so the live ones are a prefix.
    assign live  = FILL_W'(idx) < fill;
    assign match = (entry.code_point == req.code_point) &&
                   (entry.font_number == req.font_number);

    always_comb
    begin
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        old_idx_next = old_idx_reg;
        oldest_next  = oldest_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (vld)
        begin
            if (live && !found_reg && match)
            begin
                found_next   = 1'b1;
                hit_idx_next = idx;
            end
            if ((idx == '0) || (entry.stamp < oldest_reg))
            begin
                oldest_next  = entry.stamp;
                old_idx_next = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg <= hit_idx_next;
        old_idx_reg <= old_idx_next;
        oldest_reg  <= oldest_next;
    end

    assign found   = found_reg;
    assign hit_idx = hit_idx_reg;
    assign old_idx = old_idx_reg;

endmodule

// File: rtl/lru_tag_cache_lookup.sv
// Top level: fully associative LRU tag cache lookup.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------
//  request   | start & !busy      | req  (code_point, font_number)
//  response  | done, one cycle    | rsp  (hit, slot_index, evicted)
//
// From accept to the done strobe a transaction does one read of the tag
// memory per slot, a drain state while the last read data folds into the
// scan, one write-back, then the registered done strobe.
// busy drops in the cycle that shows done, so the next transaction can be
// accepted there. No clearing pass: a fill count marks the live entries.
// The response cannot be stalled; done is a single-cycle strobe.
`timescale 1ns / 1ps

module lru_tag_cache_lookup #(
    parameter int SLOTS = ltcl_pkg::SLOTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ltcl_pkg::req_t req,
    output logic           done,
    output ltcl_pkg::rsp_t rsp
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS+1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    ltcl_pkg::req_t               req_reg;
    logic [IDX_W-1:0]             addr_reg, addr_next;
    logic                         rd_vld_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [ltcl_pkg::STAMP_W-1:0] use_cnt_reg, use_cnt_next;
    logic                         done_reg, done_next;
    ltcl_pkg::rsp_t               rsp_reg, rsp_next;

    logic                         accept;
    logic                         last_rd;
    logic                         full;
    logic                         found;
    logic [IDX_W-1:0]             hit_idx;
    logic [IDX_W-1:0]             old_idx;
    logic [IDX_W-1:0]             chosen;
    logic [IDX_W+ltcl_pkg::SLOT_W-1:0] chosen_ext;
    logic                         we;
    ltcl_pkg::entry_t             wdata;
    ltcl_pkg::entry_t             rdata;

    assign accept  = start && (state_reg == ST_IDLE);
    assign last_rd = (addr_reg == IDX_W'(SLOTS - 1));
    assign full    = (fill_reg == FILL_W'(SLOTS));

    // Victim choice: hit slot, else first empty slot, else LRU slot.
    assign chosen     = found ? hit_idx : (full ? old_idx : fill_reg[IDX_W-1:0]);
    assign chosen_ext = {{ltcl_pkg::SLOT_W{1'b0}}, chosen};

    assign we                = (state_reg == ST_WRITE);
    assign wdata.code_point  = req_reg.code_point;
    assign wdata.font_number = req_reg.font_number;
    assign wdata.stamp       = use_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        fill_next    = fill_reg;
        use_cnt_next = use_cnt_reg + 1'b1;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                use_cnt_next = use_cnt_reg;
                if (start)
                begin
                    state_next = ST_SCAN;
                    addr_next  = '0;
                end
            end
            ST_SCAN:
            begin
                use_cnt_next = use_cnt_reg;
                if (last_rd)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // Last read data is on rdata here; the scan unit takes it
                // at the edge that ends this cycle.
                use_cnt_next = use_cnt_reg;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next          = ST_IDLE;
                done_next           = 1'b1;
                rsp_next.hit        = found;
                rsp_next.slot_index = chosen_ext[ltcl_pkg::SLOT_W-1:0];
                rsp_next.evicted    = !found && full;
                if (!found && !full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            default:
            begin
                use_cnt_next = use_cnt_reg;
                state_next   = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            fill_reg    <= '0;
            use_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_vld_reg  <= (state_reg == ST_SCAN);
            fill_reg    <= fill_next;
            use_cnt_reg <= use_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        rsp_reg    <= rsp_next;
        if (accept)
        begin
            req_reg <= req;
        end
    end

    ltcl_tag_ram #(
        .SLOTS (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (chosen),
        .wdata (wdata),
        .re    (state_reg == ST_SCAN),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    ltcl_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept),
        .vld     (rd_vld_reg),
        .idx     (rd_idx_reg),
        .entry   (rdata),
        .req     (req_reg),
        .fill    (fill_reg),
        .found   (found),
        .hit_idx (hit_idx),
        .old_idx (old_idx)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: rtl/ltcl_checker.sv
// Port-level checker for the LRU tag cache lookup, bound to the top level.
`timescale 1ns / 1ps
`include "lru_tag_cache_lookup_assert.svh"

module ltcl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input ltcl_pkg::rsp_t rsp
);

    `LTCL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `LTCL_ASSERT_NOW(a_done_idle, done, !busy, "done strobe while busy")
    `LTCL_ASSERT_NOW(a_busy_fall_done, $fell(busy), done, "busy dropped without response")
    `LTCL_ASSERT_NEXT(a_done_single, done, !done, "done strobe longer than one cycle")
    `LTCL_ASSERT_NOW(a_hit_no_evict, done && rsp.hit, !rsp.evicted, "hit flagged as eviction")

endmodule

bind lru_tag_cache_lookup ltcl_checker u_ltcl_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// File: verif/tb.sv
// Testbench for lru_tag_cache_lookup: directed and random lookups checked against an LRU model.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = ltcl_pkg::SLOTS_DEFAULT;
    localparam int TAG_W = ltcl_pkg::CP_W + ltcl_pkg::FONT_W;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ltcl_pkg::req_t req = '0;
    logic done;
    ltcl_pkg::rsp_t rsp;

    lru_tag_cache_lookup #(.SLOTS(SLOTS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Tag store mirror
    bit                           slot_valid [SLOTS];
    logic [ltcl_pkg::CP_W-1:0]    slot_cp    [SLOTS];
    logic [ltcl_pkg::FONT_W-1:0]  slot_font  [SLOTS];
    logic [ltcl_pkg::STAMP_W-1:0] slot_stamp [SLOTS];
    logic [ltcl_pkg::STAMP_W-1:0] use_count;

    ltcl_pkg::rsp_t expected_slots [$];
    ltcl_pkg::req_t tag_pool [$];
    int   fail_count = 0;
    int   idle_max = 6;

    // One search pass: first hit, first empty slot, oldest stamp; then update the mirror.
    function automatic ltcl_pkg::rsp_t resolve_slot(ltcl_pkg::req_t r);
        int                           hit_at;
        int                           free_at;
        int                           old_at;
        int                           pick;
        logic [ltcl_pkg::STAMP_W-1:0] oldest;
        ltcl_pkg::rsp_t               res;
        hit_at = -1;
        free_at = -1;
        old_at = 0;
        oldest = slot_stamp[0];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i])
            begin
                if (hit_at < 0 && slot_cp[i] == r.code_point && slot_font[i] == r.font_number)
                    hit_at = i;
            end
            else if (free_at < 0)
                free_at = i;
            if (slot_stamp[i] < oldest)
            begin
                oldest = slot_stamp[i];
                old_at = i;
            end
        end
        use_count = use_count + 1;
        res = '0;
        if (hit_at >= 0)
        begin
            slot_stamp[hit_at] = use_count;
            res.hit = 1'b1;
            res.slot_index = hit_at[ltcl_pkg::SLOT_W-1:0];
            return res;
        end
        if (free_at >= 0)
            pick = free_at;
        else
        begin
            pick = old_at;
            res.evicted = 1'b1;
        end
        slot_cp[pick] = r.code_point;
        slot_font[pick] = r.font_number;
        slot_valid[pick] = 1'b1;
        slot_stamp[pick] = use_count;
        res.slot_index = pick[ltcl_pkg::SLOT_W-1:0];
        return res;
    endfunction

    function automatic ltcl_pkg::req_t random_tag();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TAG_W-1:0];
    endfunction

    // Start stays high across back-to-back transactions; it only drops when there is a gap.
    task automatic send_lookup(input ltcl_pkg::req_t r);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            // sometimes wait until every queued response has been checked before the gap starts
            if ($urandom_range(0, 3) == 0)
                while (expected_slots.size() != 0)
                    @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        expected_slots.push_back(resolve_slot(r));
    endtask

    task automatic send_tag(input logic [ltcl_pkg::CP_W-1:0] cp,
                            input logic [ltcl_pkg::FONT_W-1:0] font);
        ltcl_pkg::req_t r;
        r.code_point = cp;
        r.font_number = font;
        send_lookup(r);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_slots.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_tag('0, '0);                       // all-zero tag into an empty store
        send_tag('0, '0);                       // hit
        send_tag('1, '1);
        send_tag('1, '0);
        send_tag('0, '1);
        send_tag('1, '1);
        send_tag(21'h155555, 16'h5555);
        send_tag(21'h0AAAAA, 16'hAAAA);
        send_tag(21'h000001, 16'h0000);         // differs from a stored tag in one code point bit
        send_tag(21'h000000, 16'h0001);         // differs in one font bit
        send_tag(21'h100000, 16'h8000);
        send_tag(21'h155555, 16'hAAAA);         // code point stored, font not
        send_tag(21'h0AAAAA, 16'h5555);
        send_tag('1, '0);
        send_tag('0, '1);
        send_tag(21'h0AAAAA, 16'hAAAA);
        send_tag('0, '0);
        send_tag(21'h100000, 16'h8000);
    endtask

    // Fill the store, reorder recency by touching a few entries, then force evictions.
    task automatic test_fill_evict();
        ltcl_pkg::req_t fresh;
        idle_max = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            fresh = random_tag();
            tag_pool.push_back(fresh);
            send_lookup(fresh);
        end
        idle_max = 6;
        for (int i = 0; i < 16; i++)
            send_lookup(tag_pool[$urandom_range(0, tag_pool.size() - 1)]);
        for (int i = 0; i < 24; i++)
            send_lookup(random_tag());
        tag_pool.delete();
    endtask

    // Working-set traffic: mostly pool tags, some one-bit near misses, some fresh tags.
    task automatic test_working_set(input int pool_n, input int count, input int gap_max);
        ltcl_pkg::req_t      r;
        logic [TAG_W-1:0]    flip;
        int                  sel;
        idle_max = gap_max;
        tag_pool.delete();
        for (int i = 0; i < pool_n; i++)
            tag_pool.push_back(random_tag());
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            r = tag_pool[$urandom_range(0, pool_n - 1)];
            if (sel >= 90)
                r = random_tag();
            else if (sel >= 80)
            begin
                flip = '0;
                flip[$urandom_range(0, TAG_W - 1)] = 1'b1;
                r = r ^ flip;
            end
            send_lookup(r);
        end
    endtask

    task automatic test_fresh_tags(input int count);
        idle_max = 6;
        for (int i = 0; i < count; i++)
            send_lookup(random_tag());
    endtask

    // Response checker
    always @(posedge clk)
    begin
        ltcl_pkg::rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("unexpected transaction: hit=%0d slot_index=%0d evicted=%0d",
                       rsp.hit, rsp.slot_index, rsp.evicted);
                fail_count++;
            end
            else
            begin
                want = expected_slots.pop_front();
                if (rsp.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
                    fail_count++;
                end
                if (rsp.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
                    fail_count++;
                end
                if (rsp.evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_cp[i] = '0;
            slot_font[i] = '0;
            slot_stamp[i] = '0;
        end
        use_count = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extremes();
        test_fill_evict();
        test_working_set(48, 300, 6);
        drain_results();
        test_working_set(72, 350, 0);
        test_working_set(140, 300, 6);
        drain_results();
        test_working_set(32, 150, 6);
        test_fresh_tags(120);

        start <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("lru_tag_cache_lookup regression: pass");
        else
            $display("lru_tag_cache_lookup regression: fail");
        $finish;
    end

    initial
    begin
        #1500000;
        $display("lru_tag_cache_lookup regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ltcl_pkg.sv
rtl/ltcl_tag_ram.sv
rtl/ltcl_scan.sv
rtl/lru_tag_cache_lookup.sv
rtl/ltcl_checker.sv
verif/tb.sv
